[design/dxmrg_pkg.sv]
`timescale 1ns / 1ps

package dxmrg_pkg;

  localparam int WORD_W = 31;
  localparam int SEED_W = 32;
  localparam int ORDER_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_ORDER_DEFAULT = 1024;

  localparam logic [WORD_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] MIN_MODULUS = 31'd2;

  localparam logic [WORD_W-1:0] MULTIPLIER_RESET = 31'd1;
  localparam logic [WORD_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 11'd1;
  localparam logic VARIANT_RESET = 1'b0;
  localparam logic [WORD_W-1:0] SEED_MULTIPLIER_RESET = 31'd16807;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULTIPLIER = 3'd0,
    REG_MODULUS = 3'd1,
    REG_ORDER = 3'd2,
    REG_VARIANT = 3'd3,
    REG_SEED_MULTIPLIER = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_SEED = 1'b0,
    KIND_DRAW = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OLD,
    S_RD_NEW,
    S_FIX_A,
    S_RED_A,
    S_FIX_B,
    S_RED_B,
    S_PREP,
    S_MUL,
    S_DONE,
    S_SEED_MOD,
    S_SEED_WR,
    S_SEED_MUL,
    S_SEED_RED
  } state_t;

  function automatic logic [WORD_W-1:0] mod_add(input logic [WORD_W-1:0] x,
                                                 input logic [WORD_W-1:0] y,
                                                 input logic [WORD_W-1:0] m);
    logic [WORD_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

[design/dxmrg_ram.sv]
`timescale 1ns / 1ps

module dxmrg_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dxmrg_modred.sv]
`timescale 1ns / 1ps

// bit-serial restoring remainder, one dividend bit per cycle
module dxmrg_modred (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dxmrg_pkg::SEED_W-1:0] dividend,
  input  logic [dxmrg_pkg::WORD_W-1:0] divisor,
  output logic                        done,
  output logic [dxmrg_pkg::WORD_W-1:0] rem
);
  import dxmrg_pkg::*;

  localparam int CNT_W = $clog2(SEED_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  bits_left;
  logic [SEED_W-1:0] dvd;
  logic [WORD_W-1:0] d;
  logic [WORD_W:0]   t;
  logic [WORD_W:0]   t_sub;

  assign t = {rem, dvd[SEED_W-1]};
  assign t_sub = t - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bits_left <= CNT_W'(SEED_W);
      end else if (busy) begin
        bits_left <= bits_left - CNT_W'(1);
        if (bits_left == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      d <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SEED_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        rem <= t_sub[WORD_W-1:0];
      end else begin
        rem <= t[WORD_W-1:0];
      end
    end
  end

endmodule

[design/dxmrg_modmul.sv]
`timescale 1ns / 1ps

// interleaved modular multiply, MSB of b first; needs a < m
module dxmrg_modmul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dxmrg_pkg::WORD_W-1:0] a,
  input  logic [dxmrg_pkg::WORD_W-1:0] b,
  input  logic [dxmrg_pkg::WORD_W-1:0] m,
  output logic                        done,
  output logic [dxmrg_pkg::WORD_W-1:0] prod
);
  import dxmrg_pkg::*;

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  bits_left;
  logic [WORD_W-1:0] a_q;
  logic [WORD_W-1:0] b_q;
  logic [WORD_W-1:0] m_q;
  logic [WORD_W+1:0] t;
  logic [WORD_W+1:0] m1;
  logic [WORD_W+1:0] m2;
  logic [WORD_W+1:0] t_m1;
  logic [WORD_W+1:0] t_m2;

  assign m1 = {2'b00, m_q};
  assign m2 = {1'b0, m_q, 1'b0};
  assign t = {1'b0, prod, 1'b0} + (b_q[WORD_W-1] ? {2'b00, a_q} : '0);
  assign t_m1 = t - m1;
  assign t_m2 = t - m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bits_left <= CNT_W'(WORD_W);
      end else if (busy) begin
        bits_left <= bits_left - CNT_W'(1);
        if (bits_left == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      m_q <= m;
      prod <= '0;
    end else if (busy) begin
      b_q <= {b_q[WORD_W-2:0], 1'b0};
      if (t >= m2) begin
        prod <= t_m2[WORD_W-1:0];
      end else if (t >= m1) begin
        prod <= t_m1[WORD_W-1:0];
      end else begin
        prod <= t[WORD_W-1:0];
      end
    end
  end

endmodule

[design/dx_multiple_recursive_rng.sv]
`timescale 1ns / 1ps

// DX-k-s multiple recursive generator over a prime field of up to 31 bits. A seed item
// (kind 0) refills the first k ring words and gives no result; a draw item (kind 1)
// replaces the oldest word with a new one and returns it. Multiplications and reductions
// go through two bit-serial units, a restoring remainder and an interleaved modular
// multiplier, one bit per cycle each. A draw takes one multiply, plus a remainder pass
// for each of the two ring words that is not below the current modulus. A seed takes
// one remainder pass, a multiply per further word and a remainder pass for each LCG
// value that is not below the modulus. One item is worked on at a time; a new item is
// taken while the previous result still waits in the output register. The ring is a
// single RAM of MAX_ORDER words with no clearing pass; draws before the first seed
// return undefined values.
module dx_multiple_recursive_rng #(
  parameter int MAX_ORDER = dxmrg_pkg::MAX_ORDER_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [dxmrg_pkg::CFG_IDX_W-1:0] write_index,
  input  logic [dxmrg_pkg::WORD_W-1:0]    write_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           kind,
  input  logic [dxmrg_pkg::SEED_W-1:0]    seed_value,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [dxmrg_pkg::WORD_W-1:0]    random_value
);
  import dxmrg_pkg::*;

  localparam int IDX_W = $clog2(MAX_ORDER);
  localparam int K_W = $clog2(MAX_ORDER + 1);

  logic [WORD_W-1:0]  multiplier;
  logic [WORD_W-1:0]  modulus;
  logic [ORDER_W-1:0] order;
  logic               variant;
  logic [WORD_W-1:0]  seed_multiplier;

  state_t state, state_next;
  logic [IDX_W-1:0] ring_index, ring_index_next;
  logic             result_valid_next;
  logic [WORD_W-1:0] random_value_next;
  logic [WORD_W-1:0] opa, opa_next;
  logic [WORD_W-1:0] opb, opb_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  nxt, nxt_next;

  logic [WORD_W-1:0] p_eff;
  logic [K_W-1:0]    k_eff;
  logic [K_W-1:0]    idx_inc;
  logic [IDX_W-1:0]  nxt_calc;
  logic              accept;
  logic              out_free;

  logic              red_start;
  logic [SEED_W-1:0] red_dividend;
  logic [WORD_W-1:0] red_divisor;
  logic              red_done;
  logic [WORD_W-1:0] red_rem;

  logic              mul_start;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [WORD_W-1:0] mul_m;
  logic              mul_done;
  logic [WORD_W-1:0] mul_prod;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign p_eff = (modulus < MIN_MODULUS) ? MIN_MODULUS : modulus;

  always_comb begin
    if (order == '0) begin
      k_eff = K_W'(1);
    end else if (32'(order) > 32'(MAX_ORDER)) begin
      k_eff = K_W'(MAX_ORDER);
    end else begin
      k_eff = K_W'(order);
    end
  end

  assign idx_inc = K_W'(ring_index) + K_W'(1);
  assign nxt_calc = (idx_inc >= k_eff) ? '0 : idx_inc[IDX_W-1:0];

  assign item_stall = (state != S_IDLE);
  assign accept = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULTIPLIER_RESET;
      modulus <= MODULUS_RESET;
      order <= ORDER_RESET;
      variant <= VARIANT_RESET;
      seed_multiplier <= SEED_MULTIPLIER_RESET;
    end else if (write_enable) begin
      unique case (cfg_reg_t'(write_index))
        REG_MULTIPLIER: begin
          multiplier <= write_data;
        end
        REG_MODULUS: begin
          modulus <= write_data;
        end
        REG_ORDER: begin
          order <= write_data[ORDER_W-1:0];
        end
        REG_VARIANT: begin
          variant <= write_data[0];
        end
        REG_SEED_MULTIPLIER: begin
          seed_multiplier <= write_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index <= '0;
      result_valid <= 1'b0;
    end else begin
      ring_index <= ring_index_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    random_value <= random_value_next;
    opa <= opa_next;
    opb <= opb_next;
    cnt <= cnt_next;
    nxt <= nxt_next;
  end

  always_comb begin
    state_next = state;
    ring_index_next = ring_index;
    result_valid_next = result_valid && result_stall;
    random_value_next = random_value;
    opa_next = opa;
    opb_next = opb;
    cnt_next = cnt;
    nxt_next = nxt;
    red_start = 1'b0;
    red_dividend = {1'b0, opa};
    red_divisor = p_eff;
    mul_start = 1'b0;
    mul_a = opa;
    mul_b = multiplier;
    mul_m = p_eff;
    ram_we = 1'b0;
    ram_waddr = cnt;
    ram_wdata = opa;
    ram_raddr = nxt;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_SEED) begin
            red_start = 1'b1;
            red_dividend = seed_value;
            red_divisor = p_eff - WORD_W'(1);
            cnt_next = '0;
            state_next = S_SEED_MOD;
          end else begin
            nxt_next = nxt_calc;
            state_next = S_RD_OLD;
          end
        end
      end
      S_RD_OLD: begin
        ram_raddr = nxt;
        state_next = S_RD_NEW;
      end
      S_RD_NEW: begin
        ram_raddr = ring_index;
        opa_next = ram_rdata;
        state_next = S_FIX_A;
      end
      S_FIX_A: begin
        opb_next = ram_rdata;
        if (opa >= p_eff) begin
          red_start = 1'b1;
          red_dividend = {1'b0, opa};
          state_next = S_RED_A;
        end else begin
          state_next = S_FIX_B;
        end
      end
      S_RED_A: begin
        if (red_done) begin
          opa_next = red_rem;
          state_next = S_FIX_B;
        end
      end
      S_FIX_B: begin
        if (opb >= p_eff) begin
          red_start = 1'b1;
          red_dividend = {1'b0, opb};
          state_next = S_RED_B;
        end else begin
          state_next = S_PREP;
        end
      end
      S_RED_B: begin
        if (red_done) begin
          opb_next = red_rem;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        mul_start = 1'b1;
        mul_a = variant ? mod_add(opa, opb, p_eff) : opa;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          opa_next = variant ? mul_prod : mod_add(mul_prod, opb, p_eff);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ram_we = 1'b1;
          ram_waddr = nxt;
          ring_index_next = nxt;
          result_valid_next = 1'b1;
          random_value_next = opa;
          state_next = S_IDLE;
        end
      end
      S_SEED_MOD: begin
        if (red_done) begin
          opa_next = red_rem + WORD_W'(1);
          state_next = S_SEED_WR;
        end
      end
      S_SEED_WR: begin
        ram_we = 1'b1;
        if (K_W'(cnt) == k_eff - K_W'(1)) begin
          ring_index_next = cnt;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + IDX_W'(1);
          mul_start = 1'b1;
          mul_b = seed_multiplier;
          mul_m = LCG_MOD;
          state_next = S_SEED_MUL;
        end
      end
      S_SEED_MUL: begin
        if (mul_done) begin
          if (mul_prod >= p_eff) begin
            red_start = 1'b1;
            red_dividend = {1'b0, mul_prod};
            state_next = S_SEED_RED;
          end else begin
            opa_next = mul_prod;
            state_next = S_SEED_WR;
          end
        end
      end
      S_SEED_RED: begin
        if (red_done) begin
          opa_next = red_rem;
          state_next = S_SEED_WR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  dxmrg_modred u_modred (
    .clk      (clk),
    .rst      (rst),
    .start    (red_start),
    .dividend (red_dividend),
    .divisor  (red_divisor),
    .done     (red_done),
    .rem      (red_rem)
  );

  dxmrg_modmul u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mul_m),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  dxmrg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ORDER)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[dv/dx_multiple_recursive_rng_tb.sv]
`timescale 1ns / 1ps

module dx_multiple_recursive_rng_tb;
  import dxmrg_pkg::*;

  localparam int RING_DEPTH   = MAX_ORDER_DEFAULT;
  localparam int RANDOM_ITEMS = 1575;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int END_WAIT     = 150;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    kind_t             kind;
    logic [SEED_W-1:0] seed;
  } gen_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] write_index = '0;
  logic [WORD_W-1:0]    write_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic                 kind = KIND_SEED;
  logic [SEED_W-1:0]    seed_value = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [WORD_W-1:0]    random_value;

  // generator state and register copies
  logic [WORD_W-1:0]  ring_mem [RING_DEPTH];
  int unsigned        ring_ptr;
  logic [WORD_W-1:0]  cfg_mult, cfg_mod, cfg_seed_mult;
  logic [ORDER_W-1:0] cfg_order;
  logic               cfg_variant;

  gen_item_t          pending_items[$];
  logic [WORD_W-1:0]  expected_words[$];
  int unsigned        items_queued;
  int unsigned        items_taken;
  int unsigned        results_seen;
  int unsigned        mismatch_cnt;
  int unsigned        cycle_cnt;
  int unsigned        burst_left, gap_left;
  int unsigned        hold_left, holds_done, mode_left, stall_mode;

  dx_multiple_recursive_rng #(.MAX_ORDER(RING_DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .seed_value   (seed_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .random_value (random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned ring_len();
    if (cfg_order == 0) return 1;
    if (cfg_order > RING_DEPTH) return RING_DEPTH;
    return 32'(cfg_order);
  endfunction

  task automatic advance_ring(input logic k_in, input logic [SEED_W-1:0] seed_in);
    logic [63:0] p, oldv, newv, r;
    int unsigned len, nxt;
    p = (cfg_mod < MIN_MODULUS) ? 64'(MIN_MODULUS) : 64'(cfg_mod);
    len = ring_len();
    if (k_in == KIND_SEED) begin
      ring_mem[0] = WORD_W'(64'(seed_in) % (p - 1) + 1);
      for (int i = 1; i < len; i++) begin
        ring_mem[i] = WORD_W'((64'(cfg_seed_mult) * 64'(ring_mem[i-1]) % 64'(LCG_MOD)) % p);
      end
      ring_ptr = len - 1;
    end else begin
      nxt = (ring_ptr + 1 >= len) ? 0 : ring_ptr + 1;
      oldv = 64'(ring_mem[nxt]);
      newv = 64'(ring_mem[ring_ptr]);
      if (cfg_variant == 1'b0) r = (64'(cfg_mult) * oldv + newv) % p;
      else r = (64'(cfg_mult) * (oldv + newv)) % p;
      ring_mem[nxt] = r[WORD_W-1:0];
      ring_ptr = nxt;
      expected_words.push_back(r[WORD_W-1:0]);
    end
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    case (idx)
      REG_MULTIPLIER:      cfg_mult = data;
      REG_MODULUS:         cfg_mod = data;
      REG_ORDER:           cfg_order = data[ORDER_W-1:0];
      REG_VARIANT:         cfg_variant = data[0];
      REG_SEED_MULTIPLIER: cfg_seed_mult = data;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [WORD_W-1:0] mult, input logic [WORD_W-1:0] modv,
                          input logic [ORDER_W-1:0] ord, input logic vsel,
                          input logic [WORD_W-1:0] smult);
    put_reg(REG_MULTIPLIER, mult);
    put_reg(REG_MODULUS, modv);
    put_reg(REG_ORDER, WORD_W'(ord));
    put_reg(REG_VARIANT, WORD_W'(vsel));
    put_reg(REG_SEED_MULTIPLIER, smult);
    @(posedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_item(input kind_t k_in, input logic [SEED_W-1:0] seed_in);
    gen_item_t it;
    it.kind = k_in;
    it.seed = seed_in;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic drain();
    while (!(items_taken == items_queued && expected_words.size() == 0)) @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin : drv
    gen_item_t nx;
    logic      take;
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
      items_taken <= 0;
    end else begin
      take = !item_valid || !item_stall;
      if (item_valid && !item_stall) begin
        advance_ring(kind, seed_value);
        items_taken <= items_taken + 1;
      end
      if (take) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nx = pending_items.pop_front();
          item_valid <= 1'b1;
          kind       <= nx.kind;
          seed_value <= nx.seed;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
      holds_done   <= 0;
      mode_left    <= 0;
      stall_mode   <= 0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if ((results_seen >= 200 && holds_done == 0) ||
                 (results_seen >= 900 && holds_done == 1)) begin
      hold_left    <= HOLD_CYCLES;
      holds_done   <= holds_done + 1;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left  <= $urandom_range(20, 300);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= 1'($urandom_range(0, 1));
        default: result_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : mon
    logic [WORD_W-1:0] want;
    if (rst) begin
      results_seen <= 0;
    end else if (result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (expected_words.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, random_value);
      end else begin
        want = expected_words.pop_front();
        if (random_value !== want) flag_mismatch("random_value", want, random_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stim
    logic [WORD_W-1:0]  mult_r, mod_r, smult_r;
    logic [ORDER_W-1:0] ord_r;
    logic               vsel_r;
    int unsigned        rand_items, n_items, pick;
    logic [SEED_W-1:0]  sv;

    cycle_cnt    = 0;
    mismatch_cnt = 0;
    items_queued = 0;
    ring_ptr     = 0;
    rand_items   = 0;
    cfg_mult      = MULTIPLIER_RESET;
    cfg_mod       = MODULUS_RESET;
    cfg_order     = ORDER_RESET;
    cfg_variant   = VARIANT_RESET;
    cfg_seed_mult = SEED_MULTIPLIER_RESET;
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // values after reset, single-word ring, seed extremes
    queue_item(KIND_SEED, 32'h0000_0000);
    queue_item(KIND_DRAW, '0);
    queue_item(KIND_DRAW, '0);
    queue_item(KIND_SEED, 32'hFFFF_FFFF);
    queue_item(KIND_DRAW, '0);
    queue_item(KIND_SEED, 32'h7FFF_FFFE);
    queue_item(KIND_DRAW, '0);
    queue_item(KIND_SEED, 32'h7FFF_FFFF);
    queue_item(KIND_DRAW, '0);
    drain();

    // full ring; every word written from here on
    set_regs(31'h7FFF_FFFE, LCG_MOD, 11'd1024, 1'b1, 31'h7FFF_FFFE);
    queue_item(KIND_SEED, 32'h1234_5678);
    repeat (3) queue_item(KIND_DRAW, $urandom());
    drain();

    // modulus below two, order above max, old words not below the modulus
    set_regs(31'd0, 31'd0, 11'd2047, 1'b0, 31'd1);
    repeat (2) queue_item(KIND_DRAW, $urandom());
    drain();

    // zero order, modulus one
    set_regs(31'h7FFF_FFFE, 31'd1, 11'd0, 1'b1, 31'd0);
    queue_item(KIND_SEED, 32'hFFFF_FFFF);
    queue_item(KIND_DRAW, '0);
    queue_item(KIND_SEED, 32'h0000_0000);
    queue_item(KIND_DRAW, '0);
    drain();

    // small modulus, LCG values mostly above it
    set_regs(31'd5, 31'd3, 11'd3, 1'b0, 31'h7FFF_FFFE);
    queue_item(KIND_SEED, 32'h8000_0000);
    repeat (3) queue_item(KIND_DRAW, '0);
    drain();

    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: mult_r = 31'd0;
        1: mult_r = 31'd1;
        2: mult_r = 31'h7FFF_FFFE;
        default: mult_r = WORD_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mod_r = LCG_MOD;
        4: mod_r = WORD_W'($urandom_range(0, 1));
        5, 6: mod_r = WORD_W'($urandom_range(2, 100));
        default: mod_r = WORD_W'($urandom());
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70) ord_r = ORDER_W'($urandom_range(1, 8));
      else if (pick < 90) ord_r = ORDER_W'($urandom_range(9, 64));
      else if (pick < 97) ord_r = ORDER_W'($urandom_range(65, 1023));
      else begin
        case ($urandom_range(0, 2))
          0: ord_r = 11'd0;
          1: ord_r = 11'd1024;
          default: ord_r = 11'd2047;
        endcase
      end
      vsel_r = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: smult_r = SEED_MULTIPLIER_RESET;
        1: smult_r = 31'h7FFF_FFFE;
        default: smult_r = WORD_W'($urandom());
      endcase
      set_regs(mult_r, mod_r, ord_r, vsel_r, smult_r);

      n_items = $urandom_range(15, 60);
      if ($urandom_range(0, 99) < ((ring_len() <= 64) ? 60 : 25)) begin
        queue_item(KIND_SEED, $urandom());
        rand_items++;
      end
      for (int j = 0; j < n_items; j++) begin
        if (ring_len() <= 64 && $urandom_range(0, 19) == 0) begin
          case ($urandom_range(0, 3))
            0: sv = 32'h0000_0000;
            1: sv = 32'hFFFF_FFFF;
            default: sv = $urandom();
          endcase
          queue_item(KIND_SEED, sv);
        end else begin
          queue_item(KIND_DRAW, $urandom());
        end
        rand_items++;
      end
      // phase ends on a draw so its result marks the block idle
      queue_item(KIND_DRAW, $urandom());
      rand_items++;
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
